[rtl/tlr_pkg.sv]
// tlr_pkg: shared types and constants of the thick line rasterizer
// item structs, register indexes, controller states and command/status groups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlr_pkg;

   localparam int COORD_BITS   = 12;
   localparam int MAX_RADIUS   = 3;
   localparam int RAD_BITS     = 2;
   localparam int DIM_BITS     = COORD_BITS + 1;
   localparam int CHAN_BITS    = 3;
   localparam int COLOR_BITS   = 32;
   localparam int ADDR_BITS    = 26;
   localparam int ERR_BITS     = COORD_BITS + 2;
   localparam int CMP_BITS     = ERR_BITS + 2;
   localparam int OFS_BITS     = $clog2(MAX_RADIUS + 1) + 1;
   localparam int SQ_BITS      = 2 * OFS_BITS + 1;
   localparam int PX_BITS      = COORD_BITS + 2;
   localparam int ROW_BITS     = COORD_BITS + DIM_BITS + 1;
   localparam int CSR_IDX_BITS = 2;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET    = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET   = DIM_BITS'(1024);
   localparam logic [CHAN_BITS-1:0]  CHANNELS_RESET = CHAN_BITS'(3);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_CHANNELS     = 2'd2,
      CSR_PIXEL_COLOR  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [RAD_BITS-1:0]   brush_radius;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [ADDR_BITS-1:0]  byte_address;
      logic                  write_enable;
      logic                  last_of_point;
      logic                  line_done;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic step;
      logic scan;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic en;
      logic pipe_busy;
      logic scan_last;
      logic finished;
      logic req_func;
   } status_type;

endpackage

`default_nettype wire

[rtl/thick_line_rasterizer_core.sv]
// an item is taken only in the idle state: a start loads the line, a step advances
// it, then the brush offsets are scanned, one brush offset tested per cycle while
// the output is not stalled; the address pipeline drains and a flush gives the last
// result. a step after the line ended goes straight to the flush for its single result.
// one item at a time; output stalls hold the offset scan.
// reset (synchronous, active high): no line active, config at defaults.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_rasterizer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire tlr_pkg::req_item_type            req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output tlr_pkg::rsp_item_type                 rsp_item,
   input  wire logic                             csr_we,
   input  wire logic [tlr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [tlr_pkg::COLOR_BITS-1:0]   csr_wdata
);

   tlr_pkg::cmd_type    cmd;
   tlr_pkg::status_type status;

   tlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

[rtl/tlr_ctrl.sv]
// tlr_ctrl: sequencing of one item: line update, brush scan, drain, final flush
// depends on tlr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tlr_pkg::status_type status,
   output tlr_pkg::cmd_type         cmd
);

   tlr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         tlr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_func == tlr_pkg::FUNC_START) begin
                  cmd.load = 1'b1;
                  state_in = tlr_pkg::ST_SCAN;
               end else if (!status.finished) begin
                  cmd.step = 1'b1;
                  state_in = tlr_pkg::ST_SCAN;
               end else begin
                  state_in = tlr_pkg::ST_FLUSH;
               end
            end
         end
         tlr_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.en && status.scan_last) begin
               state_in = tlr_pkg::ST_DRAIN;
            end
         end
         tlr_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = tlr_pkg::ST_FLUSH;
            end
         end
         tlr_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (status.en) begin
               state_in = tlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlr_pkg::ST_IDLE;
         end
      endcase
   end

   a_flush_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> !status.pipe_busy)
      else $error("flush while brush pipeline still busy");

   a_scan_flush_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan && cmd.flush) && !(cmd.load && cmd.step))
      else $error("conflicting commands");

   a_start_goes_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlr_pkg::ST_IDLE && req_valid && status.req_func == tlr_pkg::FUNC_START)
      |=> state_ff == tlr_pkg::ST_SCAN)
      else $error("start item did not begin a scan");

endmodule

`default_nettype wire

[rtl/tlr_datapath.sv]
// tlr_datapath: config registers, bresenham line state, brush offset scan,
// address pipeline and result register; depends on tlr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlr_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tlr_pkg::req_item_type                 req_item,
   output tlr_pkg::rsp_item_type                      rsp_item,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic                                  csr_we,
   input  wire logic [tlr_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [tlr_pkg::COLOR_BITS-1:0]        csr_wdata,
   input  wire tlr_pkg::cmd_type                      cmd,
   output tlr_pkg::status_type                        status
);

   localparam int CB = tlr_pkg::COORD_BITS;
   localparam int OB = tlr_pkg::OFS_BITS;
   localparam int PB = tlr_pkg::PX_BITS;
   localparam int DB = tlr_pkg::DIM_BITS;
   localparam int EB = tlr_pkg::ERR_BITS;
   localparam int MB = tlr_pkg::CMP_BITS;

   // configuration
   logic [DB-1:0]                  width_ff, height_ff;
   logic [tlr_pkg::CHAN_BITS-1:0]  chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tlr_pkg::WIDTH_RESET;
         height_ff <= tlr_pkg::HEIGHT_RESET;
         chan_ff   <= tlr_pkg::CHANNELS_RESET;
      end else if (csr_we) begin
         case (tlr_pkg::csr_index_type'(csr_index))
            tlr_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DB-1:0];
            tlr_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DB-1:0];
            tlr_pkg::CSR_CHANNELS:     chan_ff   <= csr_wdata[tlr_pkg::CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // line state
   logic [CB-1:0] cur_x_ff, cur_y_ff, tgt_x_ff, tgt_y_ff, dx_ff, dy_ff;
   logic [CB-1:0] cur_x_in, cur_y_in, tgt_x_in, tgt_y_in, dx_in, dy_in;
   logic          neg_x_ff, neg_y_ff, neg_x_in, neg_y_in, finished_ff;
   logic [EB-1:0] err_ff, err_in;
   logic [tlr_pkg::RAD_BITS-1:0] radius_ff, radius_in;
   logic [MB-1:0] e2_w, err_w, dx_w, dy_w;
   logic          move_x, move_y;

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      err_in    = err_ff;
      radius_in = radius_ff;
      err_w     = {{(MB-EB){err_ff[EB-1]}}, err_ff};
      e2_w      = {err_w[MB-2:0], 1'b0};
      dx_w      = MB'(dx_ff);
      dy_w      = MB'(dy_ff);
      move_x    = $signed(e2_w) > $signed(MB'(0) - dy_w);
      move_y    = $signed(e2_w) < $signed(dx_w);
      if (cmd.load) begin
         cur_x_in = req_item.start_x;
         cur_y_in = req_item.start_y;
         tgt_x_in = req_item.end_x;
         tgt_y_in = req_item.end_y;
         dx_in    = (req_item.end_x > req_item.start_x) ?
                    req_item.end_x - req_item.start_x : req_item.start_x - req_item.end_x;
         dy_in    = (req_item.end_y > req_item.start_y) ?
                    req_item.end_y - req_item.start_y : req_item.start_y - req_item.end_y;
         neg_x_in = !(req_item.start_x < req_item.end_x);
         neg_y_in = !(req_item.start_y < req_item.end_y);
         err_in   = EB'(dx_in) - EB'(dy_in);
         radius_in = (32'(req_item.brush_radius) > tlr_pkg::MAX_RADIUS) ?
                     tlr_pkg::RAD_BITS'(tlr_pkg::MAX_RADIUS) : req_item.brush_radius;
      end else if (cmd.step) begin
         if (move_x) begin
            err_w    = err_w - dy_w;
            cur_x_in = neg_x_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
         end
         if (move_y) begin
            err_w    = err_w + dx_w;
            cur_y_in = neg_y_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
         end
         err_in = err_w[EB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         tgt_x_ff    <= '0;
         tgt_y_ff    <= '0;
         dx_ff       <= '0;
         dy_ff       <= '0;
         neg_x_ff    <= 1'b0;
         neg_y_ff    <= 1'b0;
         err_ff      <= '0;
         radius_ff   <= '0;
         finished_ff <= 1'b1;
      end else if (cmd.load || cmd.step) begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         tgt_x_ff    <= tgt_x_in;
         tgt_y_ff    <= tgt_y_in;
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         neg_x_ff    <= neg_x_in;
         neg_y_ff    <= neg_y_in;
         err_ff      <= err_in;
         radius_ff   <= radius_in;
         finished_ff <= (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      end
   end

   // brush offset scan, row by row
   logic          en;
   logic [OB-1:0] tx_ff, ty_ff, rad_o, rad_next_o, ax, ay;
   logic [tlr_pkg::SQ_BITS-1:0] dist_sq, rad_sq;
   logic [PB-1:0] px_sum, py_sum;
   logic          keep;

   assign en         = !rsp_valid || rsp_ready;
   assign rad_o      = OB'(radius_ff);
   assign rad_next_o = OB'(radius_in);
   assign ax         = tx_ff[OB-1] ? OB'(0) - tx_ff : tx_ff;
   assign ay         = ty_ff[OB-1] ? OB'(0) - ty_ff : ty_ff;
   assign dist_sq    = tlr_pkg::SQ_BITS'(ax) * tlr_pkg::SQ_BITS'(ax)
                     + tlr_pkg::SQ_BITS'(ay) * tlr_pkg::SQ_BITS'(ay);
   assign rad_sq     = tlr_pkg::SQ_BITS'(rad_o) * tlr_pkg::SQ_BITS'(rad_o);
   assign px_sum     = {2'b00, cur_x_ff} + {{(PB-OB){tx_ff[OB-1]}}, tx_ff};
   assign py_sum     = {2'b00, cur_y_ff} + {{(PB-OB){ty_ff[OB-1]}}, ty_ff};
   assign keep       = (dist_sq <= rad_sq)
                     && (px_sum[PB-1:CB] == '0) && (py_sum[PB-1:CB] == '0)
                     && (DB'(px_sum[CB-1:0]) < width_ff)
                     && (DB'(py_sum[CB-1:0]) < height_ff);

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.step) begin
         tx_ff <= OB'(0) - rad_next_o;
         ty_ff <= OB'(0) - rad_next_o;
      end else if (cmd.scan && en) begin
         if (tx_ff == rad_o) begin
            tx_ff <= OB'(0) - rad_o;
            ty_ff <= ty_ff + OB'(1);
         end else begin
            tx_ff <= tx_ff + OB'(1);
         end
      end
   end

   // address pipeline: test, row address, scaled address
   logic                          a_valid_ff, a_keep_ff, b_valid_ff, b_keep_ff, pend_valid_ff;
   logic [CB-1:0]                 a_px_ff, a_py_ff, b_px_ff, b_py_ff, pend_px_ff, pend_py_ff;
   logic [tlr_pkg::ROW_BITS-1:0]  b_row_ff;
   logic [tlr_pkg::ADDR_BITS-1:0] pend_addr_ff;
   logic                          b_push, rsp_valid_ff;
   tlr_pkg::rsp_item_type         rsp_item_ff;

   assign b_push = b_valid_ff && b_keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= cmd.scan;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= (b_push && pend_valid_ff) || cmd.flush;
         if (b_push) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_keep_ff <= keep;
         a_px_ff   <= px_sum[CB-1:0];
         a_py_ff   <= py_sum[CB-1:0];
         b_keep_ff <= a_keep_ff;
         b_px_ff   <= a_px_ff;
         b_py_ff   <= a_py_ff;
         b_row_ff  <= tlr_pkg::ROW_BITS'(a_py_ff) * tlr_pkg::ROW_BITS'(width_ff)
                    + tlr_pkg::ROW_BITS'(a_px_ff);
         if (b_push) begin
            pend_px_ff   <= b_px_ff;
            pend_py_ff   <= b_py_ff;
            pend_addr_ff <= tlr_pkg::ADDR_BITS'(b_row_ff * tlr_pkg::ROW_BITS'(chan_ff));
         end
         rsp_item_ff.line_done <= finished_ff;
         if (cmd.flush && !pend_valid_ff) begin
            rsp_item_ff.pixel_x       <= cur_x_ff;
            rsp_item_ff.pixel_y       <= cur_y_ff;
            rsp_item_ff.byte_address  <= '0;
            rsp_item_ff.write_enable  <= 1'b0;
            rsp_item_ff.last_of_point <= 1'b1;
         end else begin
            rsp_item_ff.pixel_x       <= pend_px_ff;
            rsp_item_ff.pixel_y       <= pend_py_ff;
            rsp_item_ff.byte_address  <= pend_addr_ff;
            rsp_item_ff.write_enable  <= 1'b1;
            rsp_item_ff.last_of_point <= cmd.flush;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign status.en        = en;
   assign status.pipe_busy = a_valid_ff || b_valid_ff;
   assign status.scan_last = (tx_ff == rad_o) && (ty_ff == rad_o);
   assign status.finished  = finished_ff;
   assign status.req_func  = req_item.func;

   a_clipped_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.write_enable)
      |-> (rsp_item.last_of_point && rsp_item.byte_address == '0))
      else $error("write-disabled item not last or has an address");

   a_kept_in_width: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_keep_ff) |-> (DB'(a_px_ff) < width_ff))
      else $error("kept brush pixel outside image width");

   a_kept_in_height: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_keep_ff) |-> (DB'(b_py_ff) < height_ff))
      else $error("kept brush pixel outside image height");

endmodule

`default_nettype wire
